[rtl/rfpd_pkg.sv]
// Shared types and constants for the rocket flight phase detector.
`default_nettype none

package rfpd_pkg;

    localparam int HEIGHT_BITS = 16;
    localparam int DIFF_W      = HEIGHT_BITS + 1;
    localparam int INV_W       = 16;
    localparam int SPEED_W     = 16;
    localparam int PROD_W      = DIFF_W + INV_W + 1;
    localparam int FRAC_BITS   = 8;

    localparam logic [INV_W-1:0] INV_RESET = INV_W'(615);

    localparam logic signed [PROD_W-1:0] SPEED_MAX = PROD_W'(32767);
    localparam logic signed [PROD_W-1:0] SPEED_MIN = -(PROD_W'(32768));
    localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'((1 << FRAC_BITS) - 1);

    typedef enum logic [1:0] {
        PH_LAND = 2'd0,
        PH_ASC  = 2'd1,
        PH_DESC = 2'd2
    } phase_t;

    // Item leaving the height tracking stage
    typedef struct packed {
        logic                     prime;
        phase_t                   phase;
        logic                     chute;
        logic signed [DIFF_W-1:0] diff;
    } trk_t;

    // Item leaving the velocity stage
    typedef struct packed {
        logic                      prime;
        phase_t                    phase;
        logic                      chute;
        logic signed [SPEED_W-1:0] speed;
    } vel_t;

endpackage

`default_nettype wire

[rtl/rfpd_sample_if.sv]
// Height sample channel.
`default_nettype none

interface rfpd_sample_if
    import rfpd_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [HEIGHT_BITS-1:0] height;

    modport source (output valid, output height, input ready);
    modport sink   (input valid, input height, output ready);
endinterface

`default_nettype wire

[rtl/rfpd_result_if.sv]
// Result channel: phase, speed and the two latches.
`default_nettype none

interface rfpd_result_if
    import rfpd_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [1:0]                phase;
    logic signed [SPEED_W-1:0] speed;
    logic                      chute_fire;
    logic                      burnout;

    modport source (output valid, output phase, output speed, output chute_fire,
                    output burnout, input ready);
    modport sink   (input valid, input phase, input speed, input chute_fire,
                    input burnout, output ready);
endinterface

`default_nettype wire

[rtl/rfpd_cfg_if.sv]
// Configuration write channel for the sample period reciprocal.
`default_nettype none

interface rfpd_cfg_if
    import rfpd_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [INV_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/rfpd_track.sv]
// Height tracking stage: reference height, flight phase and parachute latch.
`default_nettype none

module rfpd_track
    import rfpd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    rfpd_sample_if.sink  sample,
    input  wire logic    adv,
    output logic         trk_valid,
    output trk_t         trk
);

    logic                          primed_reg, primed_next;
    phase_t                        phase_reg, phase_next;
    logic                          chute_reg, chute_next;
    logic signed [HEIGHT_BITS-1:0] ref_reg, ref_next;
    logic                          valid_reg;
    trk_t                          trk_reg, trk_next;
    logic                          accept;
    logic                          rise;
    logic                          drop;

    assign sample.ready = adv;
    assign accept       = sample.valid && adv;

    assign rise = sample.height > ref_reg;
    assign drop = sample.height < ref_reg;

    // Update phase, latch and reference for one item
    always_comb
    begin
        primed_next = 1'b1;
        phase_next  = phase_reg;
        chute_next  = chute_reg;
        ref_next    = ref_reg;
        if (!primed_reg)
        begin
            ref_next = sample.height;
        end
        else
        begin
            if (rise && phase_reg == PH_LAND)
            begin
                phase_next = PH_ASC;
            end
            if (drop && phase_next == PH_ASC)
            begin
                chute_next = 1'b1;
                phase_next = PH_DESC;
            end
            else if (rise)
            begin
                ref_next = sample.height;
            end
            if (phase_next == PH_DESC)
            begin
                ref_next = sample.height;
            end
        end
        trk_next.prime = !primed_reg;
        trk_next.phase = phase_next;
        trk_next.chute = chute_next;
        trk_next.diff  = primed_reg ?
                         (DIFF_W'(sample.height) - DIFF_W'(ref_reg)) : '0;
    end

    // Hold tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= 1'b0;
            phase_reg  <= PH_LAND;
            chute_reg  <= 1'b0;
            ref_reg    <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                valid_reg <= sample.valid;
            end
            if (accept)
            begin
                primed_reg <= primed_next;
                phase_reg  <= phase_next;
                chute_reg  <= chute_next;
                ref_reg    <= ref_next;
            end
        end
    end

    // Advance the stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            trk_reg <= trk_next;
        end
    end

    assign trk_valid = valid_reg;
    assign trk       = trk_reg;

    a_chute_holds: assert property (@(posedge clk) disable iff (!rst_n)
        chute_reg |=> chute_reg)
        else $error("parachute latch cleared");

    a_chute_phase: assert property (@(posedge clk) disable iff (!rst_n)
        chute_reg == (phase_reg == PH_DESC))
        else $error("parachute latch and descent phase disagree");

    a_land_until_primed: assert property (@(posedge clk) disable iff (!rst_n)
        !primed_reg |-> (phase_reg == PH_LAND && !chute_reg))
        else $error("phase left land before priming");

endmodule

`default_nettype wire

[rtl/rfpd_velocity.sv]
// Velocity stage: scale height difference by the period reciprocal, truncate, saturate.
`default_nettype none

module rfpd_velocity
    import rfpd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rfpd_cfg_if.sink  cfg,
    input  wire logic adv,
    input  wire logic trk_valid,
    input  trk_t      trk,
    output logic      vel_valid,
    output vel_t      vel
);

    logic [INV_W-1:0]          inv_reg;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  biased;
    logic signed [PROD_W-1:0]  quot;
    logic signed [SPEED_W-1:0] speed_sat;
    logic                      valid_reg;
    vel_t                      vel_reg;
    vel_t                      vel_next;

    assign cfg.ready = 1'b1;

    // Multiply, then shift with a bias on negatives to truncate toward zero
    always_comb
    begin
        prod   = PROD_W'(trk.diff) * $signed({2'b00, inv_reg});
        biased = prod + (prod[PROD_W-1] ? TRUNC_BIAS : '0);
        quot   = biased >>> FRAC_BITS;
        priority if (quot > SPEED_MAX)
        begin
            speed_sat = SPEED_MAX[SPEED_W-1:0];
        end
        else if (quot < SPEED_MIN)
        begin
            speed_sat = SPEED_MIN[SPEED_W-1:0];
        end
        else
        begin
            speed_sat = quot[SPEED_W-1:0];
        end
        vel_next.prime = trk.prime;
        vel_next.phase = trk.phase;
        vel_next.chute = trk.chute;
        vel_next.speed = speed_sat;
    end

    // Hold the reciprocal register and stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg   <= INV_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                inv_reg <= cfg.data;
            end
            if (adv)
            begin
                valid_reg <= trk_valid;
            end
        end
    end

    // Advance the stage payload
    always_ff @(posedge clk)
    begin
        if (adv && trk_valid)
        begin
            vel_reg <= vel_next;
        end
    end

    assign vel_valid = valid_reg;
    assign vel       = vel_reg;

endmodule

`default_nettype wire

[rtl/rfpd_burnout.sv]
// Burnout stage: running peak speed, burnout latch and the result register.
`default_nettype none

module rfpd_burnout
    import rfpd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     vel_valid,
    input  vel_t          vel,
    rfpd_result_if.source result,
    output logic          adv
);

    logic signed [SPEED_W-1:0] peak_reg, peak_next;
    logic                      burn_reg, burn_next;
    logic                      out_valid_reg;
    vel_t                      out_reg;
    logic                      out_burn_reg;
    logic                      take;

    assign adv  = !out_valid_reg || result.ready;
    assign take = adv && vel_valid;

    // Track peak speed while ascending; a slower sample latches burnout
    always_comb
    begin
        peak_next = peak_reg;
        burn_next = burn_reg;
        if (!vel.prime && vel.phase == PH_ASC)
        begin
            if (vel.speed > peak_reg)
            begin
                peak_next = vel.speed;
            end
            else if (vel.speed < peak_reg)
            begin
                burn_next = 1'b1;
            end
        end
    end

    // Hold peak, latch and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg      <= '0;
            burn_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= vel_valid;
            end
            if (take)
            begin
                peak_reg <= peak_next;
                burn_reg <= burn_next;
            end
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg      <= vel;
            out_burn_reg <= burn_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.phase      = out_reg.phase;
    assign result.speed      = out_reg.speed;
    assign result.chute_fire = out_reg.chute;
    assign result.burnout    = out_burn_reg;

    a_burnout_holds: assert property (@(posedge clk) disable iff (!rst_n)
        burn_reg |=> burn_reg)
        else $error("burnout latch cleared");

endmodule

`default_nettype wire

[rtl/rocket_flight_phase_detector.sv]
// Top level of the rocket flight phase detector.
// Each accepted item passes the tracking, velocity and result registers in turn.
// One item per cycle unless stalled; stages: height tracking, one multiply, peak compare.
// Input ready follows the output register: it drops only while a result waits unread.
// Reset (rst_n low, async): on land, unprimed, latches and peak cleared, reciprocal 615.
// The first item after reset primes the reference height and reports speed 0.
`default_nettype none

module rocket_flight_phase_detector
    import rfpd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    rfpd_sample_if.sink   sample,
    rfpd_result_if.source result,
    rfpd_cfg_if.sink      cfg
);

    logic adv;
    logic trk_valid;
    trk_t trk;
    logic vel_valid;
    vel_t vel;

    rfpd_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .adv       (adv),
        .trk_valid (trk_valid),
        .trk       (trk)
    );

    rfpd_velocity u_velocity (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .adv       (adv),
        .trk_valid (trk_valid),
        .trk       (trk),
        .vel_valid (vel_valid),
        .vel       (vel)
    );

    rfpd_burnout u_burnout (
        .clk       (clk),
        .rst_n     (rst_n),
        .vel_valid (vel_valid),
        .vel       (vel),
        .result    (result),
        .adv       (adv)
    );

endmodule

`default_nettype wire
